// File: rtl/core/fpr_pkg.sv
// Shared constants, codes and stage payload types for the pixel recolor pipeline.
package fpr_pkg;

    localparam int PALETTE_SLOTS = 16;
    localparam int SLOT_W        = (PALETTE_SLOTS > 1) ? $clog2(PALETTE_SLOTS) : 1;
    localparam int CH_W          = 8;
    localparam int SUM_W         = 10;
    localparam int PROD_W        = CH_W + SUM_W;
    localparam int DSH_SHIFT     = CH_W - 1;
    localparam int DSH_W         = SUM_W + DSH_SHIFT;
    localparam int DIV_STAGES    = 4;
    localparam int DIV_STEPS     = CH_W / DIV_STAGES;

    localparam logic [CH_W:0] SLOT_LIMIT = (CH_W + 1)'(PALETTE_SLOTS);

    typedef enum logic [0:0] {
        OP_RECOLOR = 1'b0,
        OP_WRITE   = 1'b1
    } fpr_op_t;

    typedef logic [2:0][CH_W-1:0] fpr_rgb_t;

    typedef struct packed {
        logic             hit;
        logic [CH_W-1:0]  alpha;
        fpr_rgb_t         lit;
        fpr_rgb_t         flat;
        fpr_rgb_t         tgt;
        logic [SUM_W-1:0] lit_sum;
        logic [SUM_W-1:0] flat_sum;
    } fpr_pix_t;

    typedef struct packed {
        logic                     use_div;
        logic [CH_W-1:0]          alpha;
        logic [DSH_W-1:0]         dsh;
        logic [2:0][PROD_W-1:0]   rem;
        fpr_rgb_t                 quo;
        fpr_rgb_t                 res;
    } fpr_div_t;

endpackage

// File: rtl/core/filament_pixel_recolor.sv
// Top level of the palette-driven thumbnail pixel recolor pipeline.
// Registered stages from request accept to result valid: lookup, shade, 4 divide stages.
// Throughput: one request per cycle unless m_ready back-pressure stalls; palette writes give no result.
// Stalls on m_ready back-pressure stage by stage; bubbles are squeezed out.
// Reset (aresetn low, synchronous): pipeline emptied, all palette slots invalid.
module filament_pixel_recolor (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_operation,
    input  logic [7:0]  s_lit_red,
    input  logic [7:0]  s_lit_green,
    input  logic [7:0]  s_lit_blue,
    input  logic [7:0]  s_lit_alpha,
    input  logic [7:0]  s_flat_red,
    input  logic [7:0]  s_flat_green,
    input  logic [7:0]  s_flat_blue,
    input  logic [7:0]  s_flat_alpha,
    input  logic [3:0]  s_slot_index,
    input  logic [23:0] s_slot_color,
    input  logic        s_slot_enabled,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_red,
    output logic [7:0]  m_out_green,
    output logic [7:0]  m_out_blue,
    output logic [7:0]  m_out_alpha
);

    fpr_pkg::fpr_pix_t  pix_item;
    logic               pix_valid, pix_ready;
    fpr_pkg::fpr_div_t  div_item  [fpr_pkg::DIV_STAGES+1];
    logic               div_valid [fpr_pkg::DIV_STAGES+1];
    logic               div_ready [fpr_pkg::DIV_STAGES+1];

    fpr_palette u_palette (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_valid),
        .in_ready     (s_ready),
        .operation    (s_operation),
        .lit_red      (s_lit_red),
        .lit_green    (s_lit_green),
        .lit_blue     (s_lit_blue),
        .lit_alpha    (s_lit_alpha),
        .flat_red     (s_flat_red),
        .flat_green   (s_flat_green),
        .flat_blue    (s_flat_blue),
        .flat_alpha   (s_flat_alpha),
        .slot_index   (s_slot_index),
        .slot_color   (s_slot_color),
        .slot_enabled (s_slot_enabled),
        .out_valid    (pix_valid),
        .out_ready    (pix_ready),
        .out_item     (pix_item)
    );

    fpr_shade u_shade (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (pix_valid),
        .in_ready  (pix_ready),
        .in_item   (pix_item),
        .out_valid (div_valid[0]),
        .out_ready (div_ready[0]),
        .out_item  (div_item[0])
    );

    for (genvar g = 0; g < fpr_pkg::DIV_STAGES; g++) begin : g_div
        fpr_divstage u_divstage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (div_valid[g]),
            .in_ready  (div_ready[g]),
            .in_item   (div_item[g]),
            .out_valid (div_valid[g+1]),
            .out_ready (div_ready[g+1]),
            .out_item  (div_item[g+1])
        );
    end

    assign div_ready[fpr_pkg::DIV_STAGES] = m_ready;
    assign m_valid     = div_valid[fpr_pkg::DIV_STAGES];
    assign m_out_red   = div_item[fpr_pkg::DIV_STAGES].res[2];
    assign m_out_green = div_item[fpr_pkg::DIV_STAGES].res[1];
    assign m_out_blue  = div_item[fpr_pkg::DIV_STAGES].res[0];
    assign m_out_alpha = div_item[fpr_pkg::DIV_STAGES].alpha;

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

// File: rtl/core/fpr_palette.sv
// Palette storage, slot decode and first pipeline stage (lookup and channel sums).
module fpr_palette (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     operation,
    input  logic [7:0]               lit_red,
    input  logic [7:0]               lit_green,
    input  logic [7:0]               lit_blue,
    input  logic [7:0]               lit_alpha,
    input  logic [7:0]               flat_red,
    input  logic [7:0]               flat_green,
    input  logic [7:0]               flat_blue,
    input  logic [7:0]               flat_alpha,
    input  logic [3:0]               slot_index,
    input  logic [23:0]              slot_color,
    input  logic                     slot_enabled,
    output logic                     out_valid,
    input  logic                     out_ready,
    output fpr_pkg::fpr_pix_t        out_item
);

    fpr_pkg::fpr_rgb_t                  pal_color_reg [fpr_pkg::PALETTE_SLOTS];
    logic [fpr_pkg::PALETTE_SLOTS-1:0]  pal_valid_reg;

    logic                        valid_reg, valid_next;
    fpr_pkg::fpr_pix_t           item_reg, item_next;
    logic                        in_fire, wr_fire, slot_ok;
    logic [fpr_pkg::CH_W-1:0]    slot8;
    logic [fpr_pkg::SLOT_W-1:0]  rd_idx, wr_idx;

    assign in_ready = !valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;
    assign wr_fire  = in_fire && (operation == fpr_pkg::OP_WRITE) &&
                      ((fpr_pkg::CH_W + 1)'(slot_index) < fpr_pkg::SLOT_LIMIT);
    assign wr_idx   = fpr_pkg::SLOT_W'(slot_index);

    // flat alpha carries 255 - slot
    assign slot8   = ~flat_alpha;
    assign rd_idx  = fpr_pkg::SLOT_W'(slot8);
    assign slot_ok = ({1'b0, slot8} < fpr_pkg::SLOT_LIMIT) && pal_valid_reg[rd_idx];

    always_comb begin
        item_next.hit      = (lit_alpha != 8'd0) && slot_ok;
        item_next.alpha    = lit_alpha;
        item_next.lit      = {lit_red, lit_green, lit_blue};
        item_next.flat     = {flat_red, flat_green, flat_blue};
        item_next.tgt      = pal_color_reg[rd_idx];
        item_next.lit_sum  = 10'(lit_red) + 10'(lit_green) + 10'(lit_blue);
        item_next.flat_sum = 10'(flat_red) + 10'(flat_green) + 10'(flat_blue);
    end

    always_comb begin
        valid_next = valid_reg;
        if (in_fire && (operation == fpr_pkg::OP_RECOLOR)) begin
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= 1'b0;
            pal_valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
            if (wr_fire) begin
                pal_valid_reg[wr_idx] <= slot_enabled;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_fire) begin
            pal_color_reg[wr_idx] <= slot_color;
        end
        if (in_fire && (operation == fpr_pkg::OP_RECOLOR)) begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    a_write_sets_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_fire |=> pal_valid_reg[$past(wr_idx)] == $past(slot_enabled))
        else $error("palette valid flag not updated by write");

    a_bg_no_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && (item_reg.alpha == 8'd0) |-> !item_reg.hit)
        else $error("background pixel flagged for recolor");

endmodule

// File: rtl/core/fpr_shade.sv
// Second stage: rule select, add-and-clamp shading and dividend products.
module fpr_shade (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  fpr_pkg::fpr_pix_t    in_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output fpr_pkg::fpr_div_t    out_item
);

    logic               valid_reg, valid_next;
    fpr_pkg::fpr_div_t  item_reg, item_next;
    logic               in_fire, flat_zero, lit_ge;
    logic signed [10:0] diff [3];
    fpr_pkg::fpr_rgb_t  added;

    assign in_ready  = !valid_reg || out_ready;
    assign in_fire   = in_valid && in_ready;
    assign flat_zero = (in_item.flat_sum == '0);
    assign lit_ge    = (in_item.lit_sum >= in_item.flat_sum);

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            diff[c] = $signed({3'b000, in_item.tgt[c]}) + $signed({3'b000, in_item.lit[c]})
                      - $signed({3'b000, in_item.flat[c]});
            if (diff[c] < 0) begin
                added[c] = 8'd0;
            end else if (diff[c] > 11'sd255) begin
                added[c] = 8'd255;
            end else begin
                added[c] = diff[c][7:0];
            end
        end
    end

    always_comb begin
        item_next.use_div = in_item.hit && !flat_zero && !lit_ge;
        item_next.alpha   = in_item.alpha;
        item_next.dsh     = {in_item.flat_sum, {fpr_pkg::DSH_SHIFT{1'b0}}};
        item_next.quo     = '0;
        for (int c = 0; c < 3; c++) begin
            item_next.rem[c] = fpr_pkg::PROD_W'(in_item.tgt[c]) *
                               fpr_pkg::PROD_W'(in_item.lit_sum);
        end
        if (!in_item.hit) begin
            item_next.res = in_item.lit;
        end else if (flat_zero) begin
            item_next.res = in_item.tgt;
        end else if (lit_ge) begin
            item_next.res = added;
        end else begin
            item_next.res = '0;
        end
    end

    always_comb begin
        valid_next = valid_reg;
        if (in_fire) begin
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    // quotient must fit in one channel
    a_quot_fits: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && item_reg.use_div |-> item_reg.rem[0] < {item_reg.dsh, 1'b0})
        else $error("scale dividend too large for 8-bit quotient");

endmodule

// File: rtl/core/fpr_divstage.sv
// One restoring-division stage: two quotient bits per channel, shared divisor.
module fpr_divstage (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  fpr_pkg::fpr_div_t    in_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output fpr_pkg::fpr_div_t    out_item
);

    logic               valid_reg, valid_next;
    fpr_pkg::fpr_div_t  item_reg, item_next;
    logic               in_fire;

    assign in_ready = !valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;

    always_comb begin
        item_next = in_item;
        for (int s = 0; s < fpr_pkg::DIV_STEPS; s++) begin
            for (int c = 0; c < 3; c++) begin
                if (item_next.rem[c] >= fpr_pkg::PROD_W'(item_next.dsh)) begin
                    item_next.rem[c] = item_next.rem[c] - fpr_pkg::PROD_W'(item_next.dsh);
                    item_next.quo[c] = {item_next.quo[c][fpr_pkg::CH_W-2:0], 1'b1};
                end else begin
                    item_next.quo[c] = {item_next.quo[c][fpr_pkg::CH_W-2:0], 1'b0};
                end
            end
            item_next.dsh = item_next.dsh >> 1;
        end
        if (item_next.use_div) begin
            item_next.res = item_next.quo;
        end
    end

    always_comb begin
        valid_next = valid_reg;
        if (in_fire) begin
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

// File: test/tb_top.sv
// Self-checking testbench for filament_pixel_recolor: palette writes, pixel shading rules, random traffic.
module tb_top;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 16;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        fpr_pkg::fpr_op_t  op;
        fpr_pkg::fpr_rgb_t lit;
        logic [7:0]        lit_alpha;
        fpr_pkg::fpr_rgb_t flat;
        logic [7:0]        flat_alpha;
        logic [3:0]        slot;
        logic [23:0]       color;
        logic              enabled;
    } pixel_req_t;

    typedef struct packed {
        fpr_pkg::fpr_rgb_t rgb;
        logic [7:0]        alpha;
    } pixel_out_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic        s_operation;
    logic [7:0]  s_lit_red, s_lit_green, s_lit_blue, s_lit_alpha;
    logic [7:0]  s_flat_red, s_flat_green, s_flat_blue, s_flat_alpha;
    logic [3:0]  s_slot_index;
    logic [23:0] s_slot_color;
    logic        s_slot_enabled;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_out_red, m_out_green, m_out_blue, m_out_alpha;

    logic [23:0] palette_rgb [fpr_pkg::PALETTE_SLOTS];
    logic        palette_on [fpr_pkg::PALETTE_SLOTS];
    pixel_out_t  expected_pixels [$];
    pixel_out_t  got_pixel, want_pixel;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int cycle_count = 0;
    int mismatches = 0;
    int writes_sent = 0;
    int pixels_sent = 0;
    int pixels_checked = 0;

    filament_pixel_recolor u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_operation    (s_operation),
        .s_lit_red      (s_lit_red),
        .s_lit_green    (s_lit_green),
        .s_lit_blue     (s_lit_blue),
        .s_lit_alpha    (s_lit_alpha),
        .s_flat_red     (s_flat_red),
        .s_flat_green   (s_flat_green),
        .s_flat_blue    (s_flat_blue),
        .s_flat_alpha   (s_flat_alpha),
        .s_slot_index   (s_slot_index),
        .s_slot_color   (s_slot_color),
        .s_slot_enabled (s_slot_enabled),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_red      (m_out_red),
        .m_out_green    (m_out_green),
        .m_out_blue     (m_out_blue),
        .m_out_alpha    (m_out_alpha)
    );

    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycle_count, expected_pixels.size());
            $display("** filament_pixel_recolor: FAILED **");
            $finish;
        end
    end

    function automatic pixel_out_t recolor_pixel(pixel_req_t r);
        pixel_out_t        o;
        fpr_pkg::fpr_rgb_t tgt;
        int                slot;
        int                lit_sum;
        int                flat_sum;
        int                v;
        o.rgb = r.lit;
        o.alpha = r.lit_alpha;
        slot = 255 - int'(r.flat_alpha);
        if (r.lit_alpha != 8'd0 && slot < fpr_pkg::PALETTE_SLOTS && palette_on[slot]) begin
            tgt = palette_rgb[slot];
            lit_sum = int'(r.lit[0]) + int'(r.lit[1]) + int'(r.lit[2]);
            flat_sum = int'(r.flat[0]) + int'(r.flat[1]) + int'(r.flat[2]);
            for (int c = 0; c < 3; c++) begin
                if (flat_sum == 0) begin
                    o.rgb[c] = tgt[c];
                end else if (lit_sum >= flat_sum) begin
                    v = int'(tgt[c]) + int'(r.lit[c]) - int'(r.flat[c]);
                    if (v < 0) v = 0;
                    if (v > 255) v = 255;
                    o.rgb[c] = 8'(v);
                end else begin
                    o.rgb[c] = 8'((int'(tgt[c]) * lit_sum) / flat_sum);
                end
            end
        end
        return o;
    endfunction

    // unused fields carry random bits
    function automatic pixel_req_t random_filler();
        logic [95:0] raw;
        raw = {$urandom, $urandom, $urandom};
        return raw[$bits(pixel_req_t)-1:0];
    endfunction

    function automatic pixel_req_t palette_write(int slot, logic [23:0] color, logic en);
        pixel_req_t r;
        r = random_filler();
        r.op = fpr_pkg::OP_WRITE;
        r.slot = 4'(slot);
        r.color = color;
        r.enabled = en;
        return r;
    endfunction

    function automatic pixel_req_t pixel(logic [23:0] lit, logic [7:0] la,
                                         logic [23:0] flat, logic [7:0] fa);
        pixel_req_t r;
        r = random_filler();
        r.op = fpr_pkg::OP_RECOLOR;
        r.lit = lit;
        r.lit_alpha = la;
        r.flat = flat;
        r.flat_alpha = fa;
        return r;
    endfunction

    function automatic pixel_req_t random_request();
        pixel_req_t r;
        int         shade_mode;
        int         v;
        r = random_filler();
        if ($urandom_range(99) < 15) begin
            r.op = fpr_pkg::OP_WRITE;
            if ($urandom_range(9) == 0) r.color = $urandom_range(1) ? 24'hFFFFFF : 24'h000000;
            r.enabled = ($urandom_range(99) < 80);
            return r;
        end
        r.op = fpr_pkg::OP_RECOLOR;
        if ($urandom_range(99) < 85) begin
            r.flat_alpha = 8'(255 - $urandom_range(fpr_pkg::PALETTE_SLOTS - 1));
        end
        v = $urandom_range(99);
        if (v < 8) r.lit_alpha = 8'd0;
        else if (v < 16) r.lit_alpha = 8'hFF;
        else r.lit_alpha = 8'($urandom_range(1, 255));
        shade_mode = $urandom_range(9);
        case (shade_mode)
            0: begin
                r.flat = '0;
            end
            1, 2, 3: begin
                for (int c = 0; c < 3; c++) begin
                    v = int'(r.flat[c]) + $urandom_range(80) - 40;
                    if (v < 0) v = 0;
                    if (v > 255) v = 255;
                    r.lit[c] = 8'(v);
                end
            end
            4, 5: begin
                for (int c = 0; c < 3; c++) begin
                    r.lit[c] = 8'((int'(r.flat[c]) * $urandom_range(100)) / 100);
                end
            end
            6: begin
                for (int c = 0; c < 3; c++) begin
                    r.lit[c] = $urandom_range(1) ? 8'hFF : 8'h00;
                    r.flat[c] = $urandom_range(1) ? 8'hFF : 8'h00;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic send_request(input pixel_req_t r);
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid        <= 1'b1;
        s_operation    <= r.op;
        s_lit_red      <= r.lit[2];
        s_lit_green    <= r.lit[1];
        s_lit_blue     <= r.lit[0];
        s_lit_alpha    <= r.lit_alpha;
        s_flat_red     <= r.flat[2];
        s_flat_green   <= r.flat[1];
        s_flat_blue    <= r.flat[0];
        s_flat_alpha   <= r.flat_alpha;
        s_slot_index   <= r.slot;
        s_slot_color   <= r.color;
        s_slot_enabled <= r.enabled;
        do @(posedge aclk); while (!s_ready);
        if (r.op == fpr_pkg::OP_WRITE) begin
            if (int'(r.slot) < fpr_pkg::PALETTE_SLOTS) begin
                palette_rgb[r.slot] = r.color;
                palette_on[r.slot] = r.enabled;
            end
            writes_sent++;
        end else begin
            expected_pixels.push_back(recolor_pixel(r));
            pixels_sent++;
        end
    endtask

    task automatic report_mismatch(string what, pixel_out_t want, pixel_out_t got);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $display("mismatch (%s) at cycle %0d: expected rgba %h %h %h %h, got %h %h %h %h",
                     what, cycle_count, want.rgb[2], want.rgb[1], want.rgb[0], want.alpha,
                     got.rgb[2], got.rgb[1], got.rgb[0], got.alpha);
        end
    endtask

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
        if (aresetn && m_valid && m_ready) begin
            got_pixel = {m_out_red, m_out_green, m_out_blue, m_out_alpha};
            if (expected_pixels.size() == 0) begin
                report_mismatch("no request pending", '0, got_pixel);
            end else begin
                want_pixel = expected_pixels.pop_front();
                pixels_checked++;
                if (got_pixel.rgb[2] != want_pixel.rgb[2] || got_pixel.rgb[1] != want_pixel.rgb[1]
                    || got_pixel.rgb[0] != want_pixel.rgb[0]
                    || got_pixel.alpha != want_pixel.alpha) begin
                    report_mismatch("pixel", want_pixel, got_pixel);
                end
            end
        end
    end

    task automatic test_pass_through();
        send_request(palette_write(0, 24'hFF8000, 1'b1));
        send_request(palette_write(5, 24'h123456, 1'b0));
        send_request(pixel(24'h102030, 8'h00, 24'h000000, 8'hFF));   // background
        send_request(pixel(24'h405060, 8'h80, 24'h111111, 8'hEF));   // slot past palette
        send_request(pixel(24'h405060, 8'hFF, 24'h111111, 8'h00));   // slot 255
        send_request(pixel(24'hA0B0C0, 8'h01, 24'h111111, 8'hFA));   // disabled slot
        send_request(pixel(24'hFFFFFF, 8'h7F, 24'h111111, 8'hF8));   // never written
    endtask

    task automatic test_shading_rules();
        send_request(palette_write(15, 24'h00FF7F, 1'b1));
        send_request(palette_write(9, 24'hFFFFFF, 1'b1));
        send_request(pixel(24'h204060, 8'hFF, 24'h000000, 8'hFF));   // flat black
        send_request(pixel(24'hFFFFFF, 8'hFF, 24'h0A141E, 8'hFF));   // brighter, clamp high
        send_request(pixel(24'h00C8C8, 8'h40, 24'h643232, 8'hF0));   // brighter, clamp low
        send_request(pixel(24'hFFFFFF, 8'hFF, 24'hFFFFFF, 8'hF6));   // equal sums
        send_request(pixel(24'h0A0A0A, 8'h80, 24'hFFFFFF, 8'hFF));   // darker
        send_request(pixel(24'hFFFFFE, 8'hFF, 24'hFFFFFF, 8'hF6));   // darker by one
        send_request(pixel(24'h000000, 8'h01, 24'h010000, 8'hF0));   // darker to zero
        send_request(palette_write(0, 24'hFF8000, 1'b0));
        send_request(pixel(24'h808080, 8'hFF, 24'h404040, 8'hFF));
        send_request(palette_write(0, 24'h000000, 1'b1));
        send_request(pixel(24'h808080, 8'hFF, 24'h404040, 8'hFF));
    endtask

    task automatic test_random_traffic(int count, int send_pct, int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int i = 0; i < count; i++) begin
            send_request(random_request());
        end
    endtask

    initial begin
        aresetn        <= 1'b0;
        s_valid        <= 1'b0;
        s_operation    <= fpr_pkg::OP_RECOLOR;
        s_lit_red      <= '0;
        s_lit_green    <= '0;
        s_lit_blue     <= '0;
        s_lit_alpha    <= '0;
        s_flat_red     <= '0;
        s_flat_green   <= '0;
        s_flat_blue    <= '0;
        s_flat_alpha   <= '0;
        s_slot_index   <= '0;
        s_slot_color   <= '0;
        s_slot_enabled <= 1'b0;
        for (int i = 0; i < fpr_pkg::PALETTE_SLOTS; i++) begin
            palette_rgb[i] = '0;
            palette_on[i] = 1'b0;
        end
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        test_pass_through();
        test_shading_rules();
        test_random_traffic(670, 9, 79);
        test_random_traffic(670, 79, 9);
        test_random_traffic(670, 0, 0);
        s_valid <= 1'b0;

        while (expected_pixels.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("sent %0d palette writes and %0d pixels over %0d cycles",
                 writes_sent, pixels_sent, cycle_count);
        $display("checked %0d recolored pixels, %0d mismatches", pixels_checked, mismatches);
        if (mismatches == 0 && expected_pixels.size() == 0) begin
            $display("** filament_pixel_recolor: PASSED **");
        end else begin
            $display("** filament_pixel_recolor: FAILED **");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/fpr_pkg.sv
rtl/core/fpr_palette.sv
rtl/core/fpr_shade.sv
rtl/core/fpr_divstage.sv
rtl/core/filament_pixel_recolor.sv
test/tb_top.sv
